// ===== rtl/nsmte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and byte tables for the note symbol MIDI track encoder.
package nsmte_pkg;

    localparam int DELTA_W = 28;
    localparam int COUNT_W = 32;
    localparam int IDX_W   = 4;
    localparam int TICK_W  = 11;

    // Command codes on the input channel
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_NOTE   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMPO    = 2'd0;
    localparam logic [1:0] CFG_PROGRAM  = 2'd1;
    localparam logic [1:0] CFG_VELOCITY = 2'd2;

    localparam logic [23:0] TEMPO_RESET    = 24'd500000;
    localparam logic [6:0]  PROGRAM_RESET  = 7'd0;
    localparam logic [6:0]  VELOCITY_RESET = 7'd96;

    localparam logic [7:0]         SYMBOL_LIMIT = 8'd104;
    localparam logic [6:0]         LOWEST_NOTE  = 7'd60;
    localparam logic [DELTA_W-1:0] DELTA_MAX    = 28'hFFF_FFFF;

    // Event bytes
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] META_PREFIX = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] TEMPO_LEN   = 8'h03;
    localparam logic [7:0] PROG_CHANGE = 8'hC0;
    localparam logic [7:0] NOTE_ON     = 8'h90;
    localparam logic [7:0] NOTE_OFF    = 8'h80;
    localparam logic [7:0] META_EOT    = 8'h2F;

    // Byte counts of each event sequence, without the variable-length delta
    localparam logic [IDX_W-1:0] START_LEN        = 4'd10;
    localparam logic [IDX_W-1:0] NOTE_FIXED_LEN   = 4'd8;
    localparam logic [IDX_W-1:0] FINISH_FIXED_LEN = 4'd3;
    localparam logic [IDX_W-1:0] ERROR_LEN        = 4'd1;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_NOTE   = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [6:0]         note;
        logic [1:0]         dur;
        logic [DELTA_W-1:0] delta;
        logic [1:0]         dlen_m1;
        logic [COUNT_W-1:0] tlen;
    } job_t;

    typedef struct packed {
        logic [23:0] tempo;
        logic [6:0]  program_num;
        logic [6:0]  velocity;
    } cfg_t;

    function automatic logic [TICK_W-1:0] dur_ticks(input logic [1:0] code);
        case (code)
            2'd0:    dur_ticks = 11'd240;
            2'd1:    dur_ticks = 11'd480;
            2'd2:    dur_ticks = 11'd960;
            default: dur_ticks = 11'd1920;
        endcase
    endfunction

    // Two-byte variable-length encoding of each duration
    function automatic logic [7:0] dur_hi(input logic [1:0] code);
        case (code)
            2'd0:    dur_hi = 8'h81;
            2'd1:    dur_hi = 8'h83;
            2'd2:    dur_hi = 8'h87;
            default: dur_hi = 8'h8F;
        endcase
    endfunction

    function automatic logic [7:0] dur_lo(input logic [1:0] code);
        case (code)
            2'd0:    dur_lo = 8'h70;
            2'd1:    dur_lo = 8'h60;
            2'd2:    dur_lo = 8'h40;
            default: dur_lo = 8'h00;
        endcase
    endfunction

    // Number of 7-bit groups in a delta, minus one
    function automatic logic [1:0] delta_len_m1(input logic [DELTA_W-1:0] v);
        if (v[27:21] != 7'd0) begin
            delta_len_m1 = 2'd3;
        end else if (v[20:14] != 7'd0) begin
            delta_len_m1 = 2'd2;
        end else if (v[13:7] != 7'd0) begin
            delta_len_m1 = 2'd1;
        end else begin
            delta_len_m1 = 2'd0;
        end
    endfunction

endpackage

// ===== rtl/nsmte_front.sv =====
`timescale 1ns / 1ps
// Front end: accept commands, track pending delta and byte count, queue byte jobs.
module nsmte_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_cmd,
    input  logic [7:0]       s_note_symbol,
    input  logic             q_full,
    output logic             q_push,
    output nsmte_pkg::job_t  q_job
);
    import nsmte_pkg::*;

    logic [DELTA_W-1:0] pending_reg, pending_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               accept;
    logic               push;
    logic               sym_bad;
    logic [5:0]         pitch;
    logic [1:0]         dlen_m1;
    logic [DELTA_W:0]   rest_sum;
    logic [DELTA_W-1:0] rest_sat;
    logic [IDX_W-1:0]   add_len;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_sat;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && push;

    assign sym_bad = s_note_symbol >= SYMBOL_LIMIT;
    assign pitch   = s_note_symbol[7:2];
    assign dlen_m1 = delta_len_m1(pending_reg);

    assign rest_sum = {1'b0, pending_reg} + (DELTA_W+1)'(dur_ticks(s_note_symbol[1:0]));
    assign rest_sat = (rest_sum > {1'b0, DELTA_MAX}) ? DELTA_MAX : rest_sum[DELTA_W-1:0];

    assign add_len   = ((s_cmd == CMD_FINISH) ? FINISH_FIXED_LEN : NOTE_FIXED_LEN)
                       + {2'b00, dlen_m1} + 4'd1;
    assign count_sum = {1'b0, count_reg} + (COUNT_W+1)'(add_len);
    assign count_sat = count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];

    always_comb begin
        push          = 1'b0;
        pending_next  = pending_reg;
        count_next    = count_reg;
        q_job.kind    = KIND_NOTE;
        q_job.note    = LOWEST_NOTE + {1'b0, pitch} - 7'd1;
        q_job.dur     = s_note_symbol[1:0];
        q_job.delta   = pending_reg;
        q_job.dlen_m1 = dlen_m1;
        q_job.tlen    = count_sat;
        case (s_cmd)
            CMD_START: begin
                push         = 1'b1;
                q_job.kind   = KIND_START;
                pending_next = '0;
                count_next   = COUNT_W'(START_LEN);
            end
            CMD_NOTE: begin
                if (sym_bad) begin
                    push       = 1'b1;
                    q_job.kind = KIND_ERROR;
                end else if (pitch == 6'd0) begin
                    pending_next = rest_sat;
                end else begin
                    push         = 1'b1;
                    pending_next = '0;
                    count_next   = count_sat;
                end
            end
            CMD_FINISH: begin
                push         = 1'b1;
                q_job.kind   = KIND_FINISH;
                pending_next = '0;
                count_next   = count_sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            count_reg   <= '0;
        end else if (accept) begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== rtl/nsmte_fifo.sv =====
`timescale 1ns / 1ps
// Small job queue between the front end and the byte sequencer.
module nsmte_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  nsmte_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output nsmte_pkg::job_t  head_job
);
    import nsmte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/nsmte_back.sv =====
`timescale 1ns / 1ps
// Back end: walk one queued job byte by byte into the registered output stage.
module nsmte_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  nsmte_pkg::cfg_t              cfg,
    input  logic                         q_valid,
    input  nsmte_pkg::job_t              q_job,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_data_byte,
    output logic                         m_last,
    output logic                         m_error,
    output logic [nsmte_pkg::COUNT_W-1:0] m_track_length
);
    import nsmte_pkg::*;

    logic             busy_reg, busy_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_data_reg;
    logic               m_last_reg;
    logic               m_error_reg;
    logic [COUNT_W-1:0] m_tlen_reg;

    logic [IDX_W-1:0] dlen;
    logic [IDX_W-1:0] total;
    logic [IDX_W-1:0] tail_idx;
    logic [1:0]       group;
    logic [7:0]       delta_byte;
    logic [7:0]       tail_byte;
    logic [7:0]       cur_byte;
    logic             is_last;
    logic             out_free;
    logic             step;

    assign dlen     = {2'b00, job_reg.dlen_m1} + 4'd1;
    assign tail_idx = idx_reg - dlen;
    assign group    = job_reg.dlen_m1 - idx_reg[1:0];

    always_comb begin
        case (job_reg.kind)
            KIND_START:  total = START_LEN;
            KIND_NOTE:   total = NOTE_FIXED_LEN + dlen;
            KIND_FINISH: total = FINISH_FIXED_LEN + dlen;
            default:     total = ERROR_LEN;
        endcase
    end

    assign is_last = idx_reg == (total - 4'd1);

    // Most significant group first; all but the final group carry the continuation bit.
    always_comb begin
        case (group)
            2'd0:    delta_byte = {1'b0, job_reg.delta[6:0]};
            2'd1:    delta_byte = {1'b1, job_reg.delta[13:7]};
            2'd2:    delta_byte = {1'b1, job_reg.delta[20:14]};
            default: delta_byte = {1'b1, job_reg.delta[27:21]};
        endcase
    end

    always_comb begin
        tail_byte = BYTE_ZERO;
        if (job_reg.kind == KIND_FINISH) begin
            case (tail_idx)
                4'd0:    tail_byte = META_PREFIX;
                4'd1:    tail_byte = META_EOT;
                default: tail_byte = BYTE_ZERO;
            endcase
        end else begin
            case (tail_idx)
                4'd0:    tail_byte = NOTE_ON;
                4'd1:    tail_byte = {1'b0, job_reg.note};
                4'd2:    tail_byte = {1'b0, cfg.velocity};
                4'd3:    tail_byte = dur_hi(job_reg.dur);
                4'd4:    tail_byte = dur_lo(job_reg.dur);
                4'd5:    tail_byte = NOTE_OFF;
                4'd6:    tail_byte = {1'b0, job_reg.note};
                default: tail_byte = BYTE_ZERO;
            endcase
        end
    end

    always_comb begin
        case (job_reg.kind)
            KIND_START: begin
                case (idx_reg)
                    4'd1:    cur_byte = META_PREFIX;
                    4'd2:    cur_byte = META_TEMPO;
                    4'd3:    cur_byte = TEMPO_LEN;
                    4'd4:    cur_byte = cfg.tempo[23:16];
                    4'd5:    cur_byte = cfg.tempo[15:8];
                    4'd6:    cur_byte = cfg.tempo[7:0];
                    4'd8:    cur_byte = PROG_CHANGE;
                    4'd9:    cur_byte = {1'b0, cfg.program_num};
                    default: cur_byte = BYTE_ZERO;
                endcase
            end
            KIND_NOTE, KIND_FINISH: begin
                cur_byte = (idx_reg < dlen) ? delta_byte : tail_byte;
            end
            default: cur_byte = BYTE_ZERO;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;
    assign step     = busy_reg && out_free;
    assign q_pop    = q_valid && (!busy_reg || (step && is_last));

    always_comb begin
        busy_next    = busy_reg;
        job_next     = job_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            job_next  = q_job;
            idx_next  = '0;
        end else if (step && is_last) begin
            busy_next = 1'b0;
        end else if (step) begin
            idx_next = idx_reg + 4'd1;
        end
        if (out_free) begin
            m_valid_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (step) begin
            m_data_reg  <= cur_byte;
            m_last_reg  <= is_last;
            m_error_reg <= job_reg.kind == KIND_ERROR;
            m_tlen_reg  <= (is_last && job_reg.kind == KIND_FINISH) ? job_reg.tlen : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_byte    = m_data_reg;
    assign m_last         = m_last_reg;
    assign m_error        = m_error_reg;
    assign m_track_length = m_tlen_reg;

    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg < total)
        else $error("byte index ran past the end of its job");

    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_error_reg) |-> (m_last_reg && m_data_reg == BYTE_ZERO))
        else $error("error result is not a single zero byte");

    a_length_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tlen_reg != '0) |-> m_last_reg)
        else $error("track length shown before the last byte");

    a_pop_starts_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (busy_reg && idx_reg == '0))
        else $error("popped job did not start at its first byte");

endmodule

// ===== rtl/note_symbol_midi_track_encoder.sv =====
`timescale 1ns / 1ps
// Top level of the note symbol MIDI track encoder.
// Each command transfer becomes a burst of MIDI track bytes, one byte per output
// transfer, with last set on the final byte of the burst. A start command gives
// the ten-byte tempo and program-change preamble, a note gives nine to twelve
// bytes (its rest delta takes one to four bytes), a finish gives four to seven
// bytes and reports the track byte count on its last byte, and a bad symbol gives
// one zero byte flagged as an error. Rests and command code 3 give nothing. The
// byte sequencer in the back end emits one byte per clock while the output is
// ready; the front end accepts a command per clock while the job queue
// (QUEUE_DEPTH entries) has room, and a waiting output byte does not stop it.
// Write the configuration only while idle.
module note_symbol_midi_track_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [7:0]                    s_note_symbol,
    // byte channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_data_byte,
    output logic                          m_last,
    output logic                          m_error,
    output logic [nsmte_pkg::COUNT_W-1:0] m_track_length,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [23:0]                   cfg_wdata
);
    import nsmte_pkg::*;

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_valid;
    job_t q_head_job;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tempo       <= TEMPO_RESET;
            cfg_reg.program_num <= PROGRAM_RESET;
            cfg_reg.velocity    <= VELOCITY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TEMPO:    cfg_reg.tempo       <= cfg_wdata;
                CFG_PROGRAM:  cfg_reg.program_num <= cfg_wdata[6:0];
                CFG_VELOCITY: cfg_reg.velocity    <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Classify commands, update the track state and hand byte jobs to the queue.
    nsmte_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_note_symbol (s_note_symbol),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_push_job)
    );

    // Decouple command intake from byte output.
    nsmte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job)
    );

    // Advance through each job one byte per output transfer.
    nsmte_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_job          (q_head_job),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_last         (m_last),
        .m_error        (m_error),
        .m_track_length (m_track_length)
    );

endmodule
